@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SRCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SRCC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/srcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcc_pkg
// Types, character codes and helpers for the sentence checksum checker.
// ----------------------------------------------------------------------------
package srcc_pkg;

	localparam int MAX_LINE_BYTES = 120;
	localparam int CNT_W          = 7;
	localparam int HDR_LEN        = 6;
	localparam int TAIL_LEN       = 5;

	typedef logic [7:0] byte_t;
	typedef logic [CNT_W-1:0] cnt_t;
	// element 0 is the first byte of the line
	typedef logic [0:HDR_LEN-1][7:0] hdr_t;
	// element 0 is the oldest byte of the window
	typedef logic [TAIL_LEN-1:0][7:0] tail_t;

	localparam byte_t CH_STAR = 8'h2A;
	localparam byte_t CH_LF   = 8'h0A;
	localparam byte_t CH_NUL  = 8'h00;
	localparam byte_t CH_0    = 8'h30;
	localparam byte_t CH_9    = 8'h39;
	localparam byte_t CH_A    = 8'h41;
	localparam byte_t CH_F    = 8'h46;

	localparam hdr_t HDR_PFO = "$RMPFO";
	localparam hdr_t HDR_SET = "$RMSET";
	localparam hdr_t HDR_VAR = "$RMVAR";
	localparam hdr_t HDR_CMD = "$RMCMD";
	localparam hdr_t HDR_REQ = "$RMREQ";

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_PFO  = 3'd1,
		KIND_SET  = 3'd2,
		KIND_VAR  = 3'd3,
		KIND_CMD  = 3'd4,
		KIND_REQ  = 3'd5
	} kind_t;

	// Line state as it stands after the current byte is taken in.
	typedef struct packed {
		hdr_t  hdr;
		tail_t tail;
		byte_t running_xor;
		cnt_t  content_len;
		logic  is_lf;
		logic  full;
	} line_view_t;

	typedef struct packed {
		logic  line_end;
		logic  line_valid;
		kind_t message_kind;
		logic  overflow;
		byte_t received_checksum;
	} result_t;

	// Upper-case hex only; anything else reads as zero.
	function automatic logic [3:0] hex_digit(input byte_t c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= CH_0 && c <= CH_9) begin
			v = c[3:0];
		end else if (c >= CH_A && c <= CH_F) begin
			v = 4'(c[3:0] + 4'd9);
		end
		return v;
	endfunction

	function automatic kind_t classify(input hdr_t h);
		kind_t k;
		k = KIND_NONE;
		priority if (h == HDR_PFO) k = KIND_PFO;
		else if (h == HDR_SET) k = KIND_SET;
		else if (h == HDR_VAR) k = KIND_VAR;
		else if (h == HDR_CMD) k = KIND_CMD;
		else if (h == HDR_REQ) k = KIND_REQ;
		else k = KIND_NONE;
		return k;
	endfunction

endpackage

@@ src/srcc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcc_in_if
// Byte request channel: valid, ready and one received character.
// ----------------------------------------------------------------------------
interface srcc_in_if;
	logic               valid;
	logic               ready;
	srcc_pkg::byte_t    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/srcc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcc_out_if
// Result request channel: one line status per received byte.
// ----------------------------------------------------------------------------
interface srcc_out_if;
	logic               valid;
	logic               ready;
	logic               line_end;
	logic               line_valid;
	logic [2:0]         message_kind;
	logic               overflow;
	srcc_pkg::byte_t    received_checksum;

	modport source (output valid, output line_end, output line_valid,
		output message_kind, output overflow, output received_checksum,
		input ready);
	modport sink   (input valid, input line_end, input line_valid,
		input message_kind, input overflow, input received_checksum,
		output ready);
endinterface

@@ src/srcc_line_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcc_line_track
// Per-line state: byte count, header, tail window and running XOR.
// ----------------------------------------------------------------------------
module srcc_line_track (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  srcc_pkg::byte_t         rx_byte,
	output srcc_pkg::line_view_t    view
);

	srcc_pkg::cnt_t   byte_count_q;
	srcc_pkg::cnt_t   content_len_q;
	logic             zero_seen_q;
	srcc_pkg::hdr_t   hdr_q;
	srcc_pkg::tail_t  tail_q;
	srcc_pkg::byte_t  xor_q;

	srcc_pkg::cnt_t   count_d;
	srcc_pkg::cnt_t   len_d;
	logic             zero_d;
	srcc_pkg::hdr_t   hdr_d;
	srcc_pkg::tail_t  tail_d;
	srcc_pkg::byte_t  xor_d;
	logic             clear;

	always_comb begin
		count_d = srcc_pkg::cnt_t'(byte_count_q + 1'b1);
		len_d   = content_len_q;
		zero_d  = zero_seen_q;
		hdr_d   = hdr_q;
		tail_d  = tail_q;
		xor_d   = xor_q;

		for (int i = 0; i < srcc_pkg::HDR_LEN; i++) begin
			if (byte_count_q == srcc_pkg::cnt_t'(i)) begin
				hdr_d[i] = rx_byte;
			end
		end

		if (!zero_seen_q) begin
			if (rx_byte == srcc_pkg::CH_NUL) begin
				zero_d = 1'b1;
			end else begin
				// byte leaving the window joins the sum once index 0 has gone by
				if (content_len_q >= srcc_pkg::cnt_t'(srcc_pkg::HDR_LEN)) begin
					xor_d = xor_q ^ tail_q[0];
				end
				for (int i = 0; i < srcc_pkg::TAIL_LEN - 1; i++) begin
					tail_d[i] = tail_q[i+1];
				end
				tail_d[srcc_pkg::TAIL_LEN-1] = rx_byte;
				if (content_len_q != '1) begin
					len_d = srcc_pkg::cnt_t'(content_len_q + 1'b1);
				end
			end
		end

		view.hdr         = hdr_d;
		view.tail        = tail_d;
		view.running_xor = xor_d;
		view.content_len = len_d;
		view.is_lf       = (rx_byte == srcc_pkg::CH_LF);
		view.full        = (count_d >= srcc_pkg::cnt_t'(srcc_pkg::MAX_LINE_BYTES));
		clear            = view.is_lf || view.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			content_len_q <= '0;
			zero_seen_q   <= 1'b0;
			hdr_q         <= '0;
			tail_q        <= '0;
			xor_q         <= '0;
		end else if (step) begin
			if (clear) begin
				byte_count_q  <= '0;
				content_len_q <= '0;
				zero_seen_q   <= 1'b0;
				hdr_q         <= '0;
				tail_q        <= '0;
				xor_q         <= '0;
			end else begin
				byte_count_q  <= count_d;
				content_len_q <= len_d;
				zero_seen_q   <= zero_d;
				hdr_q         <= hdr_d;
				tail_q        <= tail_d;
				xor_q         <= xor_d;
			end
		end
	end

endmodule

@@ src/srcc_line_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcc_line_check
// End-of-line check: star position, hex checksum compare, prefix class.
// ----------------------------------------------------------------------------
module srcc_line_check (
	input  srcc_pkg::line_view_t    view,
	output srcc_pkg::result_t       res
);

	logic             star_ok;
	srcc_pkg::byte_t  sum;
	logic             sum_ok;

	always_comb begin
		star_ok = view.is_lf
			&& (view.content_len >= srcc_pkg::cnt_t'(srcc_pkg::TAIL_LEN))
			&& (view.tail[0] == srcc_pkg::CH_STAR);
		sum     = {srcc_pkg::hex_digit(view.tail[1]), srcc_pkg::hex_digit(view.tail[2])};
		sum_ok  = star_ok && (sum == view.running_xor);

		res.line_end          = view.is_lf;
		res.line_valid        = sum_ok;
		res.message_kind      = sum_ok ? srcc_pkg::classify(view.hdr) : srcc_pkg::KIND_NONE;
		res.overflow          = !view.is_lf && view.full;
		res.received_checksum = star_ok ? sum : '0;
	end

endmodule

@@ src/sentence_receiver_checksum_check_unit.sv @@
`timescale 1ns / 1ps
// A byte reaches its result through the input register, then the result register.
// Throughput: one byte per cycle if results drain; a single line-state pass per byte.
// A stalled result holds the byte path one stage deep; one request still lands in the
// input register while the result waits.
// Reset: arst_n clears both stage valids and all line state at once.
// ----------------------------------------------------------------------------
// sentence_receiver_checksum_check_unit
// Checks "$BODY*HH" sentences for star position and XOR checksum, flags
// overlong lines and classifies the $RM prefix, one result per byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sentence_receiver_checksum_check_unit (
	input  logic            clk,
	input  logic            arst_n,
	srcc_in_if.sink         rx,
	srcc_out_if.source      res
);

	// Stage 1: the accepted byte waits here for the line-state pass.
	logic                   valid_s1;
	srcc_pkg::byte_t        byte_s1;

	// Result register, parted from stage 1 so input keeps flowing.
	logic                   res_valid_q;
	srcc_pkg::result_t      res_q;

	srcc_pkg::line_view_t   view;
	srcc_pkg::result_t      res_d;

	logic                   adv;
	logic                   rx_take;

	// Stage 1 moves on whenever the result register is empty or being drained.
	assign adv      = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv;
	assign rx_take  = rx.valid && rx.ready;

	srcc_line_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.view    (view)
	);

	srcc_line_check u_check (
		.view (view),
		.res  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1 <= rx_take || (valid_s1 && !adv);
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx.rx_byte;
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.line_end          = res_q.line_end;
	assign res.line_valid        = res_q.line_valid;
	assign res.message_kind      = res_q.message_kind;
	assign res.overflow          = res_q.overflow;
	assign res.received_checksum = res_q.received_checksum;

	// A line cannot both close and overflow on the same byte.
	`SRCC_ASSERT(a_end_xor_ovf, res_valid_q |-> !(res_q.line_end && res_q.overflow), "line end with overflow")
	// A class is only reported on a checked line end.
	`SRCC_ASSERT(a_kind_valid, (res_valid_q && res_q.message_kind != srcc_pkg::KIND_NONE) |-> (res_q.line_valid && res_q.line_end), "kind without valid line")
	// Every stage-1 advance fills the result register.
	`SRCC_ASSERT(a_adv_fills, adv |=> res_valid_q, "advance lost")
	// A held stage-1 byte is neither dropped nor overwritten.
	`SRCC_ASSERT(a_s1_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1)), "stage 1 byte lost")
	// Nothing is offered while reset is applied.
	`SRCC_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> (!res_valid_q && !valid_s1), "valid during reset")

endmodule

@@ test/srcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcc_checker
// Watches the byte and result channels, predicts one line status per
// accepted byte and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module srcc_checker (
	input  logic        clk,
	input  logic        arst_n,
	srcc_in_if          rx,
	srcc_out_if         res,
	output int unsigned fail_count,
	output int unsigned pending
);
	import srcc_pkg::*;

	// line state, mirrored from the block's behavior
	cnt_t    line_cnt    = '0;
	cnt_t    content_cnt = '0;
	logic    nul_seen    = 1'b0;
	byte_t   head_buf [HDR_LEN];
	byte_t   tail_win [TAIL_LEN];
	byte_t   xor_acc     = '0;

	result_t status_q [$];

	function automatic logic [3:0] hex_nibble(input byte_t c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 10);
		end
		return v;
	endfunction

	function automatic kind_t header_kind(input hdr_t h);
		kind_t k;
		case (h)
			HDR_PFO: k = KIND_PFO;
			HDR_SET: k = KIND_SET;
			HDR_VAR: k = KIND_VAR;
			HDR_CMD: k = KIND_CMD;
			HDR_REQ: k = KIND_REQ;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic void clear_line();
		line_cnt = '0;
		content_cnt = '0;
		nul_seen = 1'b0;
		xor_acc = '0;
		foreach (head_buf[i]) head_buf[i] = '0;
		foreach (tail_win[i]) tail_win[i] = '0;
	endfunction

	initial begin
		clear_line();
		fail_count = 0;
		pending = 0;
	end

	// Advance the line state by one byte and work out its status.
	task automatic take_byte(input byte_t c, output result_t r);
		hdr_t  h;
		byte_t sum;
		r = '0;
		if (line_cnt < HDR_LEN) begin
			head_buf[line_cnt] = c;
		end
		line_cnt = line_cnt + 1'b1;
		if (!nul_seen) begin
			if (c == CH_NUL) begin
				nul_seen = 1'b1;
			end else begin
				if (content_cnt >= 6) xor_acc ^= tail_win[0];
				for (int i = 0; i < TAIL_LEN - 1; i++) tail_win[i] = tail_win[i + 1];
				tail_win[TAIL_LEN - 1] = c;
				if (content_cnt < 127) content_cnt = content_cnt + 1'b1;
			end
		end
		if (c == CH_LF) begin
			r.line_end = 1'b1;
			if (content_cnt >= 5 && tail_win[0] == CH_STAR) begin
				sum = {hex_nibble(tail_win[1]), hex_nibble(tail_win[2])};
				r.received_checksum = sum;
				if (sum == xor_acc) begin
					for (int i = 0; i < HDR_LEN; i++) h[i] = head_buf[i];
					r.line_valid = 1'b1;
					r.message_kind = header_kind(h);
				end
			end
			clear_line();
		end else if (line_cnt >= MAX_LINE_BYTES) begin
			r.overflow = 1'b1;
			clear_line();
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got, inout bit bad);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
			bad = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		bit      bad;
		if (!arst_n) begin
			clear_line();
			status_q.delete();
		end else begin
			if (rx.valid && rx.ready) begin
				take_byte(rx.rx_byte, want);
				status_q.push_back(want);
			end
			if (res.valid && res.ready) begin
				got.line_end = res.line_end;
				got.line_valid = res.line_valid;
				got.message_kind = kind_t'(res.message_kind);
				got.overflow = res.overflow;
				got.received_checksum = res.received_checksum;
				if (status_q.size() == 0) begin
					$display("%0t unexpected result: expected none, got %h", $time, got);
					fail_count++;
				end else begin
					want = status_q.pop_front();
					bad = 1'b0;
					check_field("line_end", want.line_end, got.line_end, bad);
					check_field("line_valid", want.line_valid, got.line_valid, bad);
					check_field("message_kind", want.message_kind, got.message_kind, bad);
					check_field("overflow", want.overflow, got.overflow, bad);
					check_field("received_checksum", want.received_checksum,
						got.received_checksum, bad);
					if (bad) fail_count++;
				end
			end
		end
		pending = status_q.size();
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds sentence byte streams into the checksum checker: directed lines of
// every kind, then random well-formed sentences mixed with broken ones and
// noise, with random idle cycles on both channels. The checker module does
// the prediction; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import srcc_pkg::*;

	// how a generated sentence ends
	typedef enum int {
		TAIL_GOOD,      // correct upper-case checksum
		TAIL_BAD_SUM,   // checksum off by a random nonzero value
		TAIL_LOWER_HEX, // checksum printed in lower case
		TAIL_NO_STAR,   // star replaced by another character
		TAIL_NUL        // zero byte after the checksum ends the content
	} tail_style_t;

	localparam int RANDOM_BYTES = 180;
	localparam int LONG_HOLD    = 150; // receiver hold-off, cycles

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned pending;
	byte_t       tx_bytes [$];

	srcc_in_if  rx_ch ();
	srcc_out_if res_ch ();

	sentence_receiver_checksum_check_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	srcc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Hard stop in case a request never completes.
	initial begin
		#2_000_000;
		$display("[sentence_receiver_checksum_check_unit] ERROR");
		$finish;
	end

	// --- stream building ---------------------------------------------------

	// text holds everything before the star, dollar sign included
	task automatic add_sentence(input string text, input tail_style_t style);
		byte_t sum;
		string digits;
		sum = '0;
		for (int i = 1; i < text.len(); i++) sum ^= text[i];
		for (int i = 0; i < text.len(); i++) tx_bytes.push_back(text[i]);
		if (style == TAIL_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
		if (style == TAIL_LOWER_HEX) digits = $sformatf("%02x", sum);
		else digits = $sformatf("%02X", sum);
		tx_bytes.push_back(style == TAIL_NO_STAR ? byte_t'("#") : CH_STAR);
		tx_bytes.push_back(digits[0]);
		tx_bytes.push_back(digits[1]);
		tx_bytes.push_back(8'h0D);
		if (style == TAIL_NUL) begin
			// content ends at the zero byte; what follows is ignored
			tx_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
			tx_bytes.push_back(CH_NUL);
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		end
		tx_bytes.push_back(CH_LF);
	endtask

	task automatic add_raw(input string s);
		for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
	endtask

	// n bytes of anything but a line feed, then a line feed if asked
	task automatic add_junk(input int n, input bit close);
		byte_t b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_LF) b = 8'hFF;
			tx_bytes.push_back(b);
		end
		if (close) tx_bytes.push_back(CH_LF);
	endtask

	function automatic string random_text();
		string heads [8] = '{"$RMPFO", "$RMSET", "$RMVAR", "$RMCMD", "$RMREQ",
			"$RMXYZ", "$GPGGA", "$RMPF"};
		string s;
		int    n;
		s = heads[$urandom_range(0, 7)];
		n = $urandom_range(0, 14);
		if (n != 0) s = {s, ","};
		for (int i = 1; i < n; i++) s = {s, string'(8'($urandom_range(8'h20, 8'h7E)))};
		return s;
	endfunction

	task automatic build_stream();
		int base;
		int pick;
		// every message kind with a correct checksum
		add_sentence("$RMPFO,1,2", TAIL_GOOD);
		add_sentence("$RMSET,A", TAIL_GOOD);
		add_sentence("$RMVAR,x=7", TAIL_GOOD);
		add_sentence("$RMCMD,GO", TAIL_GOOD);
		add_sentence("$RMREQ", TAIL_GOOD);
		// valid line, unknown prefix
		add_sentence("$RMXYZ,5", TAIL_GOOD);
		// checksum failures and format faults
		add_sentence("$RMSET,9", TAIL_BAD_SUM);
		add_sentence("$RMVAR,ab", TAIL_LOWER_HEX);
		add_sentence("$RMCMD,1", TAIL_NO_STAR);
		add_sentence("$RMPFO,3", TAIL_NUL);
		// short lines
		add_raw("\n");
		add_raw("*\n");
		add_raw("*00\n");
		add_raw("*00\r\n");
		// zero byte early in the line
		tx_bytes.push_back(CH_NUL);
		add_raw("$RMREQ*00\r\n");
		// extremes of the byte
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(CH_LF);
		// line feed as the last byte a line can hold, then a real overflow
		add_junk(MAX_LINE_BYTES - 1, 1'b1);
		add_junk(MAX_LINE_BYTES, 1'b0);
		add_sentence("$RMSET,after", TAIL_GOOD);

		base = tx_bytes.size();
		while (tx_bytes.size() < base + RANDOM_BYTES) begin
			pick = $urandom_range(0, 39);
			if (pick < 26) begin
				add_sentence(random_text(), TAIL_GOOD);
			end else if (pick < 29) begin
				add_sentence(random_text(), TAIL_BAD_SUM);
			end else if (pick < 31) begin
				add_sentence(random_text(), TAIL_LOWER_HEX);
			end else if (pick < 33) begin
				add_sentence(random_text(), TAIL_NO_STAR);
			end else if (pick < 36) begin
				add_sentence(random_text(), TAIL_NUL);
			end else if (pick < 39) begin
				// noise, line feeds possible, closed by a line feed
				for (int i = $urandom_range(1, 16); i > 0; i--)
					tx_bytes.push_back(8'($urandom_range(0, 255)));
				tx_bytes.push_back(CH_LF);
			end else begin
				add_junk(MAX_LINE_BYTES, 1'b0);
			end
		end
	endtask

	// --- channel drivers ---------------------------------------------------

	task automatic send_bytes();
		int gap;
		bit calm;
		calm = 1'b0;
		for (int n = 0; n < tx_bytes.size(); n++) begin
			// now and then a stretch with no idle cycles
			if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rx_ch.valid <= 1'b1;
			rx_ch.rx_byte <= tx_bytes[n];
			do @(posedge clk); while (!rx_ch.ready);
		end
		rx_ch.valid <= 1'b0;
	endtask

	// Result side: random stalls, one long hold-off so the block backs up.
	initial begin : result_sink
		int gap;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b0);
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			gap = calm ? 0 : $urandom_range(0, 7);
			if (taken == 300) gap = LONG_HOLD;
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken++;
		end
	end

	// --- main sequence -----------------------------------------------------

	initial begin
		// a real falling edge, so the asynchronous reset fires before the first clock
		arst_n = 1'b1;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		#1;
		arst_n = 1'b0;
		build_stream();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_bytes();
		// let the checker log the last request before polling the count
		@(posedge clk);
		wait (pending == 0);
		// room for any stray result from the two-stage pipe
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[sentence_receiver_checksum_check_unit] OK");
		end else begin
			$display("[sentence_receiver_checksum_check_unit] ERROR");
		end
		$finish;
	end

endmodule
